// ===== design/spq_pkg.sv =====
package spq_pkg;

    // Default queue depth in entries
    localparam int DEPTH_DEFAULT = 16;

    // Fixed field widths
    localparam int KEY_W  = 32;
    localparam int TAG_W  = 16;
    localparam int FILL_W = 5;

    // Operation codes carried in the kind field
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic             ins;   // insert the new entry (queue not full)
        logic             rem;   // remove the head entry (queue not empty)
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } cmd_t;

endpackage

// ===== design/spq_req_if.sv =====
interface spq_req_if;

    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [spq_pkg::KEY_W-1:0] key;
    logic [spq_pkg::TAG_W-1:0] tag;

    modport source (output valid, output kind, output key, output tag, input ready);
    modport sink   (input valid, input kind, input key, input tag, output ready);

endinterface

// ===== design/spq_rsp_if.sv =====
interface spq_rsp_if;

    logic                       valid;
    logic                       ready;
    logic                       out_valid;
    logic [spq_pkg::KEY_W-1:0]  out_key;
    logic [spq_pkg::TAG_W-1:0]  out_tag;
    logic                       dropped;
    logic [spq_pkg::FILL_W-1:0] fill;

    modport source (output valid, output out_valid, output out_key, output out_tag,
                    output dropped, output fill, input ready);
    modport sink   (input valid, input out_valid, input out_key, input out_tag,
                    input dropped, input fill, output ready);

endinterface

// ===== design/sorted_priority_queue.sv =====
// Sorted priority queue, smallest key first, DEPTH entries.
// req channel: kind selects enqueue (key, tag stored) or dequeue.
// rsp channel: exactly one response per request: out_valid/out_key/out_tag
// for a dequeue that found an entry, dropped for an enqueue into a full
// queue, and fill, the entry count after the request.
// Entries live in a chain of cells kept in ascending order; cell 0 is the
// head. An insert shifts every cell past the insertion point one place
// toward the tail, a removal shifts the chain one place toward the head.
// Equal keys leave in arrival order.
// The response is registered and sits in the output register in the cycle
// after the request is accepted. Throughput: one request per cycle while
// rsp is taken; the output register is the only buffer, so a held response
// holds off the next request until it is taken.
// Reset empties the queue and drops any pending response; stored entries
// are not cleared and no clearing pass is needed.
module sorted_priority_queue
#(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic                      rsp_valid_reg;
    logic                      out_valid_reg;
    logic [spq_pkg::KEY_W-1:0] out_key_reg;
    logic [spq_pkg::TAG_W-1:0] out_tag_reg;
    logic                      dropped_reg;
    logic [CW+4:0]             fill_ext;

    logic                      accept;
    logic                      full;
    logic                      empty;
    spq_pkg::cmd_t             cmd;

    logic                      keep_w  [DEPTH];
    logic [spq_pkg::KEY_W-1:0] key_w   [DEPTH];
    logic [spq_pkg::TAG_W-1:0] tag_w   [DEPTH];

    // Request handshake: free output register or one being drained
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // Broadcast command to the cells
    always_comb
    begin
        cmd.ins = accept && (req.kind == spq_pkg::KIND_ENQ) && !full;
        cmd.rem = accept && (req.kind == spq_pkg::KIND_DEQ) && !empty;
        cmd.key = req.key;
        cmd.tag = req.tag;
    end

    // Cell chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                      lk;
        logic [spq_pkg::KEY_W-1:0] lkey;
        logic [spq_pkg::TAG_W-1:0] ltag;
        logic [spq_pkg::KEY_W-1:0] rkey;
        logic [spq_pkg::TAG_W-1:0] rtag;

        if (i == 0)
        begin : g_head
            assign lk   = 1'b1;
            assign lkey = req.key;
            assign ltag = req.tag;
        end
        else
        begin : g_body
            assign lk   = keep_w[i-1];
            assign lkey = key_w[i-1];
            assign ltag = tag_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign rkey = key_w[i];
            assign rtag = tag_w[i];
        end
        else
        begin : g_inner
            assign rkey = key_w[i+1];
            assign rtag = tag_w[i+1];
        end

        spq_cell u_cell
        (
            .clk       (clk),
            .cmd       (cmd),
            .occupied  (count_reg > CW'(i)),
            .left_keep (lk),
            .left_key  (lkey),
            .left_tag  (ltag),
            .right_key (rkey),
            .right_tag (rtag),
            .keep      (keep_w[i]),
            .key       (key_w[i]),
            .tag       (tag_w[i])
        );
    end

    // Entry count after this request
    always_comb
    begin
        priority if (cmd.ins)
            count_next = count_reg + CW'(1);
        else if (cmd.rem)
            count_next = count_reg - CW'(1);
        else
            count_next = count_reg;
    end

    // Count and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_valid_reg <= cmd.rem;
            out_key_reg   <= cmd.rem ? key_w[0] : '0;
            out_tag_reg   <= cmd.rem ? tag_w[0] : '0;
            dropped_reg   <= (req.kind == spq_pkg::KIND_ENQ) && full;
        end
    end

    // Fill is reported modulo 32; count_reg already holds the updated value
    assign fill_ext = {5'd0, count_reg};

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.out_valid = out_valid_reg;
    assign rsp.out_key   = out_key_reg;
    assign rsp.out_tag   = out_tag_reg;
    assign rsp.dropped   = dropped_reg;
    assign rsp.fill      = fill_ext[spq_pkg::FILL_W-1:0];

endmodule

// ===== design/spq_cell.sv =====
module spq_cell
(
    input  logic                      clk,
    input  spq_pkg::cmd_t             cmd,
    input  logic                      occupied,
    input  logic                      left_keep,
    input  logic [spq_pkg::KEY_W-1:0] left_key,
    input  logic [spq_pkg::TAG_W-1:0] left_tag,
    input  logic [spq_pkg::KEY_W-1:0] right_key,
    input  logic [spq_pkg::TAG_W-1:0] right_tag,
    output logic                      keep,
    output logic [spq_pkg::KEY_W-1:0] key,
    output logic [spq_pkg::TAG_W-1:0] tag
);

    logic [spq_pkg::KEY_W-1:0] key_reg;
    logic [spq_pkg::TAG_W-1:0] tag_reg;
    logic [spq_pkg::KEY_W-1:0] key_next;
    logic [spq_pkg::TAG_W-1:0] tag_next;

    // Entry stays put on insert when it sorts at or before the new key
    assign keep = occupied && (key_reg <= cmd.key);

    // Next entry: hold, take the new entry, shift from left or from right
    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (cmd.ins && !keep)
        begin
            if (left_keep)
            begin
                key_next = cmd.key;
                tag_next = cmd.tag;
            end
            else
            begin
                key_next = left_key;
                tag_next = left_tag;
            end
        end
        else if (cmd.rem)
        begin
            key_next = right_key;
            tag_next = right_tag;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key = key_reg;
    assign tag = tag_reg;

endmodule

// ===== sim/sorted_priority_queue_tb.sv =====
`timescale 1ns / 100ps

module sorted_priority_queue_tb;

    localparam int DEPTH      = spq_pkg::DEPTH_DEFAULT;
    localparam int MAX_PAUSE  = 12;
    localparam int RAND_REQS  = 950;
    localparam int HANG_LIMIT = 1000;
    localparam int DRAIN_CYC  = 10;

    typedef struct packed {
        logic                      kind;
        logic [spq_pkg::KEY_W-1:0] key;
        logic [spq_pkg::TAG_W-1:0] tag;
    } queue_req_t;

    typedef struct packed {
        logic                       out_valid;
        logic [spq_pkg::KEY_W-1:0]  out_key;
        logic [spq_pkg::TAG_W-1:0]  out_tag;
        logic                       dropped;
        logic [spq_pkg::FILL_W-1:0] fill;
    } queue_rsp_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Local copies of the driven inputs, known from time zero
    logic                      req_valid = 1'b0;
    logic                      req_kind  = spq_pkg::KIND_ENQ;
    logic [spq_pkg::KEY_W-1:0] req_key   = '0;
    logic [spq_pkg::TAG_W-1:0] req_tag   = '0;
    logic                      rsp_ready = 1'b0;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    assign req_ch.valid = req_valid;
    assign req_ch.kind  = req_kind;
    assign req_ch.key   = req_key;
    assign req_ch.tag   = req_tag;
    assign rsp_ch.ready = rsp_ready;

    sorted_priority_queue #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Requests waiting to be driven, and responses predicted but not yet seen
    queue_req_t req_backlog[$];
    queue_rsp_t rsp_due[$];

    // Predicted queue contents, ascending by key
    logic [spq_pkg::KEY_W-1:0] held_key [DEPTH];
    logic [spq_pkg::TAG_W-1:0] held_tag [DEPTH];
    int                        held_count = 0;

    int total_reqs    = 0;
    int accepted_reqs = 0;
    int seen_rsps     = 0;
    int err_count     = 0;
    int req_pause     = 0;
    int rsp_pause     = 0;
    int hang_cycles   = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Pause drawn per request/response; every fourth stretch of 64 runs flat out
    function automatic int draw_pause(input int n);
        if ((n / 64) % 4 == 3)
            return 0;
        return $urandom_range(0, MAX_PAUSE);
    endfunction

    // Apply one request to the predicted queue and queue up its response
    task automatic apply_queue_op(input queue_req_t r);
        queue_rsp_t exp_rsp;
        int         pos;
        exp_rsp = '0;
        if (r.kind == spq_pkg::KIND_ENQ)
        begin
            if (held_count >= DEPTH)
                exp_rsp.dropped = 1'b1;
            else
            begin
                // insert behind every entry with key <= new key
                pos = 0;
                while (pos < held_count && held_key[pos] <= r.key)
                    pos++;
                for (int i = held_count; i > pos; i--)
                begin
                    held_key[i] = held_key[i-1];
                    held_tag[i] = held_tag[i-1];
                end
                held_key[pos] = r.key;
                held_tag[pos] = r.tag;
                held_count++;
            end
        end
        else if (held_count > 0)
        begin
            exp_rsp.out_valid = 1'b1;
            exp_rsp.out_key   = held_key[0];
            exp_rsp.out_tag   = held_tag[0];
            for (int i = 1; i < held_count; i++)
            begin
                held_key[i-1] = held_key[i];
                held_tag[i-1] = held_tag[i];
            end
            held_count--;
        end
        exp_rsp.fill = held_count[spq_pkg::FILL_W-1:0];
        rsp_due.push_back(exp_rsp);
    endtask

    task automatic report_mismatch(input string what,
                                   input logic [spq_pkg::KEY_W-1:0] got,
                                   input logic [spq_pkg::KEY_W-1:0] want);
        $display("%0t: response %0d %s: got 0x%0h, expected 0x%0h",
                 $realtime, seen_rsps, what, got, want);
        err_count++;
    endtask

    task automatic push_req(input logic kind, input logic [spq_pkg::KEY_W-1:0] key,
                            input logic [spq_pkg::TAG_W-1:0] tag);
        queue_req_t r;
        r.kind = kind;
        r.key  = key;
        r.tag  = tag;
        req_backlog.push_back(r);
        total_reqs++;
    endtask

    // Random key: heavy on a tiny range for ties, plus the extremes
    function automatic logic [spq_pkg::KEY_W-1:0] draw_key();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return spq_pkg::KEY_W'($urandom_range(0, 7));
        if (pick == 4)
            return '0;
        if (pick == 5)
            return '1;
        return $urandom();
    endfunction

    // Bursts that lean toward filling, toward draining, or neither
    task automatic gen_random_reqs(input int count);
        int   left;
        int   burst;
        int   enq_pct;
        logic kind;
        left = count;
        while (left > 0)
        begin
            case ($urandom_range(0, 2))
                0:       enq_pct = 85;
                1:       enq_pct = 20;
                default: enq_pct = 50;
            endcase
            burst = $urandom_range(4, 40);
            for (int i = 0; i < burst && left > 0; i++)
            begin
                kind = ($urandom_range(1, 100) <= enq_pct) ? spq_pkg::KIND_ENQ
                                                           : spq_pkg::KIND_DEQ;
                push_req(kind, draw_key(), spq_pkg::TAG_W'($urandom()));
                left--;
            end
        end
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        queue_req_t nxt;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_kind  <= spq_pkg::KIND_ENQ;
            req_key   <= '0;
            req_tag   <= '0;
            req_pause <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                nxt.kind = req_ch.kind;
                nxt.key  = req_ch.key;
                nxt.tag  = req_ch.tag;
                apply_queue_op(nxt);
                accepted_reqs++;
            end
            // slot free: idle out the pause, then present the next request
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_pause != 0)
                begin
                    req_valid <= 1'b0;
                    req_pause <= req_pause - 1;
                end
                else if (req_backlog.size() > 0)
                begin
                    nxt = req_backlog.pop_front();
                    req_valid <= 1'b1;
                    req_kind  <= nxt.kind;
                    req_key   <= nxt.key;
                    req_tag   <= nxt.tag;
                    req_pause <= draw_pause(accepted_reqs);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Response monitor and ready control
    always @(posedge clk or negedge rst_n)
    begin
        queue_rsp_t want;
        int         p;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rsp_pause <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (rsp_due.size() == 0)
                begin
                    $display("%0t: response %0d arrived with none due", $realtime, seen_rsps);
                    err_count++;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    if (rsp_ch.out_valid !== want.out_valid)
                        report_mismatch("out_valid", spq_pkg::KEY_W'(rsp_ch.out_valid),
                                        spq_pkg::KEY_W'(want.out_valid));
                    if (rsp_ch.out_key !== want.out_key)
                        report_mismatch("out_key", rsp_ch.out_key, want.out_key);
                    if (rsp_ch.out_tag !== want.out_tag)
                        report_mismatch("out_tag", spq_pkg::KEY_W'(rsp_ch.out_tag),
                                        spq_pkg::KEY_W'(want.out_tag));
                    if (rsp_ch.dropped !== want.dropped)
                        report_mismatch("dropped", spq_pkg::KEY_W'(rsp_ch.dropped),
                                        spq_pkg::KEY_W'(want.dropped));
                    if (rsp_ch.fill !== want.fill)
                        report_mismatch("fill", spq_pkg::KEY_W'(rsp_ch.fill),
                                        spq_pkg::KEY_W'(want.fill));
                end
                seen_rsps++;
                p = draw_pause(seen_rsps);
                if (p != 0)
                begin
                    rsp_ready <= 1'b0;
                    rsp_pause <= p - 1;
                end
            end
            else if (!rsp_ch.ready)
            begin
                if (rsp_pause == 0)
                    rsp_ready <= 1'b1;
                else
                    rsp_pause <= rsp_pause - 1;
            end
        end
    end

    // Watchdog: too long without any handshake on either side
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            hang_cycles <= 0;
        else if (hang_cycles >= HANG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            hang_cycles <= hang_cycles + 1;
    end

    initial
    begin
        // Directed: empty dequeue, extremes, ties, fill to full, overflow, partial drain
        push_req(spq_pkg::KIND_DEQ, '1, '1);
        push_req(spq_pkg::KIND_ENQ, '1, '1);
        push_req(spq_pkg::KIND_ENQ, '0, '0);
        push_req(spq_pkg::KIND_ENQ, 32'd7, 16'd1);
        push_req(spq_pkg::KIND_ENQ, 32'd7, 16'd2);
        push_req(spq_pkg::KIND_ENQ, 32'd7, 16'd3);
        push_req(spq_pkg::KIND_ENQ, 32'h8000_0000, 16'h8000);
        push_req(spq_pkg::KIND_ENQ, 32'd1, 16'h0011);
        push_req(spq_pkg::KIND_ENQ, 32'd7, 16'd4);
        push_req(spq_pkg::KIND_ENQ, 32'hFFFF_FFFE, 16'h5A5A);
        push_req(spq_pkg::KIND_ENQ, 32'd3, 16'hA5A5);
        push_req(spq_pkg::KIND_ENQ, 32'd100, 16'h1234);
        push_req(spq_pkg::KIND_ENQ, '0, 16'hFFFE);
        push_req(spq_pkg::KIND_ENQ, '1, 16'h0001);
        push_req(spq_pkg::KIND_ENQ, 32'd42, 16'h4242);
        push_req(spq_pkg::KIND_ENQ, 32'd5, 16'h0505);
        push_req(spq_pkg::KIND_ENQ, 32'h7FFF_FFFF, 16'h7FFF);
        push_req(spq_pkg::KIND_ENQ, '0, 16'hDEAD);
        for (int i = 0; i < 6; i++)
            push_req(spq_pkg::KIND_DEQ, '0, '0);

        gen_random_reqs(RAND_REQS);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait (accepted_reqs == total_reqs && rsp_due.size() == 0);
        repeat (DRAIN_CYC) @(posedge clk);

        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/spq_pkg.sv
design/spq_req_if.sv
design/spq_rsp_if.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
sim/sorted_priority_queue_tb.sv
